>>> rtl/itgi_pkg.sv
// ----------------------------------------------------------------------------
// itgi_pkg
// Shared types and constants for the inertial tilt and gyro integrator.
// ----------------------------------------------------------------------------
package itgi_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ACC_W     = 48;
    localparam int CW        = 40;   // CORDIC datapath width
    localparam int ZW        = 28;   // angle accumulator, degrees * 2^16

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_PITCH_LOAD,
        ST_PITCH_RUN,
        ST_ROLL_LOAD,
        ST_ROLL_RUN,
        ST_ACC_X,
        ST_ACC_Y,
        ST_ACC_Z,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic sqrt_start;
        logic sqrt_step;
        logic cor_load_pitch;
        logic cor_load_roll;
        logic cor_step;
        logic cor_save_pitch;
        logic cor_save_roll;
        logic [1:0] acc_sel;
        logic acc_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic cor_done;
        logic first;
        logic ok;
    } t_status;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:  r = 28'sd2949120;
            5'd1:  r = 28'sd1740967;
            5'd2:  r = 28'sd919879;
            5'd3:  r = 28'sd466945;
            5'd4:  r = 28'sd234379;
            5'd5:  r = 28'sd117304;
            5'd6:  r = 28'sd58666;
            5'd7:  r = 28'sd29335;
            5'd8:  r = 28'sd14668;
            5'd9:  r = 28'sd7334;
            5'd10: r = 28'sd3667;
            5'd11: r = 28'sd1833;
            5'd12: r = 28'sd917;
            5'd13: r = 28'sd458;
            5'd14: r = 28'sd229;
            5'd15: r = 28'sd115;
            5'd16: r = 28'sd57;
            5'd17: r = 28'sd29;
            5'd18: r = 28'sd14;
            5'd19: r = 28'sd7;
            5'd20: r = 28'sd4;
            5'd21: r = 28'sd2;
            5'd22: r = 28'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/itgi_ctrl.sv
// ----------------------------------------------------------------------------
// itgi_ctrl
// Sequencer: square root, two CORDIC passes, three accumulator updates.
// ----------------------------------------------------------------------------
module itgi_ctrl import itgi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_in_valid) n_state = ST_SQRT;
            ST_SQRT: begin
                if (i_status.first || !i_status.ok) n_state = ST_IDLE;
                else if (i_status.sqrt_done) n_state = ST_PITCH_LOAD;
            end
            ST_PITCH_LOAD: n_state = ST_PITCH_RUN;
            ST_PITCH_RUN:  if (i_status.cor_done) n_state = ST_ROLL_LOAD;
            ST_ROLL_LOAD:  n_state = ST_ROLL_RUN;
            ST_ROLL_RUN:   if (i_status.cor_done) n_state = ST_ACC_X;
            ST_ACC_X:      n_state = ST_ACC_Y;
            ST_ACC_Y:      n_state = ST_ACC_Z;
            ST_ACC_Z:      n_state = ST_OUT;
            ST_OUT:        if (!i_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
                o_cmd.sqrt_start = i_in_valid;
            end
            ST_SQRT:       o_cmd.sqrt_step = 1'b1;
            ST_PITCH_LOAD: o_cmd.cor_load_pitch = 1'b1;
            ST_PITCH_RUN: begin
                o_cmd.cor_step       = 1'b1;
                o_cmd.cor_save_pitch = i_status.cor_done;
            end
            ST_ROLL_LOAD:  o_cmd.cor_load_roll = 1'b1;
            ST_ROLL_RUN: begin
                o_cmd.cor_step      = 1'b1;
                o_cmd.cor_save_roll = i_status.cor_done;
            end
            ST_ACC_X: begin
                o_cmd.acc_step = 1'b1;
                o_cmd.acc_sel  = AX_X;
            end
            ST_ACC_Y: begin
                o_cmd.acc_step = 1'b1;
                o_cmd.acc_sel  = AX_Y;
            end
            ST_ACC_Z: begin
                o_cmd.acc_step = 1'b1;
                o_cmd.acc_sel  = AX_Z;
            end
            ST_OUT:        o_cmd.out_load = !i_out_valid || !i_out_stall;
            default:       o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/itgi_dp.sv
// ----------------------------------------------------------------------------
// itgi_dp
// Datapath: bit-pair square root, shared CORDIC unit, gyro accumulators and
// output register.
// ----------------------------------------------------------------------------
module itgi_dp import itgi_pkg::*; #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [31:0]             i_time_ms,
    input  logic                    i_sample_ok,
    input  logic signed [15:0]      i_accel_x,
    input  logic signed [15:0]      i_accel_y,
    input  logic signed [15:0]      i_accel_z,
    input  logic signed [15:0]      i_rate_x,
    input  logic signed [15:0]      i_rate_y,
    input  logic signed [15:0]      i_rate_z,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [15:0]      o_tilt_pitch,
    output logic signed [15:0]      o_tilt_roll,
    output logic signed [ACC_W-1:0] o_angle_x_sum,
    output logic signed [ACC_W-1:0] o_angle_y_sum,
    output logic signed [ACC_W-1:0] o_angle_z_sum,
    output logic                    o_sum_saturated
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SH    = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] LIM = ZW'(180 << ANGLE_FRAC_BITS);

    // captured sample
    logic [31:0]        r_prev_time;
    logic [31:0]        r_dt;
    logic               r_first, r_ok;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_first     <= 1'b0;
            r_ok        <= 1'b0;
        end else if (i_cmd.capture) begin
            r_first     <= (r_prev_time == '0);
            r_ok        <= i_sample_ok;
            r_dt        <= i_time_ms - r_prev_time;
            r_prev_time <= i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_rate_x;
            r_gy <= i_rate_y;
            r_gz <= i_rate_z;
        end
    end

    // square root of (y^2+z^2)<<28, one result bit per cycle
    logic [59:0] r_rem;
    logic [59:0] r_rad;
    logic [29:0] r_root;
    logic [4:0]  r_sq_cnt;
    logic [31:0] n_y2, n_z2;
    logic [59:0] sq_trial, sq_rem2;

    assign n_y2 = 32'(i_accel_y) * 32'(i_accel_y);
    assign n_z2 = 32'(i_accel_z) * 32'(i_accel_z);
    assign sq_rem2  = {r_rem[57:0], r_rad[59:58]};
    assign sq_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rad    <= {n_y2 + n_z2, 28'd0};
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_step && r_sq_cnt != 5'd30) begin
            r_rad    <= {r_rad[57:0], 2'b00};
            r_sq_cnt <= r_sq_cnt + 5'd1;
            if (sq_rem2 >= sq_trial) begin
                r_rem  <= sq_rem2 - sq_trial;
                r_root <= {r_root[28:0], 1'b1};
            end else begin
                r_rem  <= sq_rem2;
                r_root <= {r_root[28:0], 1'b0};
            end
        end
    end

    // CORDIC vectoring
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic [4:0]           r_ci;
    logic signed [CW-1:0] ld_x, ld_y, nx, ny;
    logic signed [ZW-1:0] ld_z, z_rnd, z_clip;
    logic signed [15:0]   r_pitch, r_roll;

    always_comb begin
        logic signed [CW-1:0] x0, y0;
        if (i_cmd.cor_load_pitch) begin
            x0 = CW'(r_az) <<< 14;
            y0 = CW'(r_ay) <<< 14;
        end else begin
            x0 = CW'({10'd0, r_root});
            y0 = -(CW'(r_ax) <<< 14);
        end
        ld_x = x0;
        ld_y = y0;
        ld_z = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                ld_x = y0;
                ld_y = -x0;
                ld_z = ZW'(90 <<< 16);
            end else begin
                ld_x = -y0;
                ld_y = x0;
                ld_z = -ZW'(90 <<< 16);
            end
        end
    end

    assign nx = (r_cy >= 0) ? r_cx + (r_cy >>> r_ci) : r_cx - (r_cy >>> r_ci);
    assign ny = (r_cy >= 0) ? r_cy - (r_cx >>> r_ci) : r_cy + (r_cx >>> r_ci);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_load_pitch || i_cmd.cor_load_roll) begin
            r_cx <= ld_x;
            r_cy <= ld_y;
            r_cz <= ld_z;
            r_ci <= '0;
        end else if (i_cmd.cor_step && !o_status.cor_done) begin
            r_cx <= nx;
            r_cy <= ny;
            r_cz <= (r_cy >= 0) ? r_cz + atan_entry(r_ci) : r_cz - atan_entry(r_ci);
            r_ci <= r_ci + 5'd1;
        end
    end

    assign z_rnd = (r_cz + ZW'(1 << (SH - 1))) >>> SH;
    always_comb begin
        z_clip = z_rnd;
        if (z_rnd > LIM) z_clip = LIM;
        if (z_rnd < -LIM) z_clip = -LIM;
        if (z_clip > ZW'(32767)) z_clip = ZW'(32767);
        if (z_clip < -ZW'(32768)) z_clip = -ZW'(32768);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_save_pitch) r_pitch <= (r_ay == 0 && r_az == 0) ? '0 : 16'(z_clip);
        if (i_cmd.cor_save_roll) begin
            r_roll <= (r_ax == 0 && r_ay == 0 && r_az == 0) ? '0 : 16'(z_clip);
        end
    end

    // saturating accumulators, one axis per cycle
    logic signed [ACC_W-1:0] r_acc [3];
    logic                    r_sat;
    logic signed [15:0]      g_sel;
    logic signed [48:0]      prod;
    logic signed [49:0]      acc_sum;
    logic signed [ACC_W-1:0] acc_new;
    logic                    acc_clip;

    always_comb begin
        case (t_axis'(i_cmd.acc_sel))
            AX_X:    g_sel = r_gx;
            AX_Y:    g_sel = r_gy;
            default: g_sel = r_gz;
        endcase
    end

    assign prod    = 49'(g_sel) * 49'($signed({1'b0, r_dt}));
    assign acc_sum = 50'(r_acc[i_cmd.acc_sel]) + 50'(prod);

    always_comb begin
        acc_clip = 1'b1;
        if (acc_sum > 50'sh0_7FFF_FFFF_FFFF) acc_new = {1'b0, {(ACC_W-1){1'b1}}};
        else if (acc_sum < -50'sh0_8000_0000_0000) acc_new = {1'b1, {(ACC_W-1){1'b0}}};
        else begin
            acc_new  = acc_sum[ACC_W-1:0];
            acc_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
            r_sat    <= 1'b0;
        end else begin
            if (i_cmd.capture) r_sat <= 1'b0;
            if (i_cmd.acc_step) begin
                r_acc[i_cmd.acc_sel] <= acc_new;
                r_sat <= r_sat | acc_clip;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_tilt_pitch    <= r_pitch;
            o_tilt_roll     <= r_roll;
            o_angle_x_sum   <= r_acc[0];
            o_angle_y_sum   <= r_acc[1];
            o_angle_z_sum   <= r_acc[2];
            o_sum_saturated <= r_sat;
        end
    end

    assign o_status.sqrt_done = (r_sq_cnt == 5'd30);
    assign o_status.cor_done  = (r_ci == 5'(STEPS));
    assign o_status.first     = r_first;
    assign o_status.ok        = r_ok;

endmodule

>>> rtl/imu_tilt_and_gyro_integrator_top.sv
// ----------------------------------------------------------------------------
// imu_tilt_and_gyro_integrator_top
// One request in, at most one result out. The first sample and a failed read
// return to idle from the square root state with no result. A good read runs
// through the square root, two CORDIC passes on one shared unit, three
// accumulator updates and the output register load. A waiting result stalls
// the sequencer only at its output load. One request at a time.
// ----------------------------------------------------------------------------
module imu_tilt_and_gyro_integrator_top import itgi_pkg::*; #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [31:0]             i_time_ms,
    input  logic                    i_sample_ok,
    input  logic signed [15:0]      i_accel_x,
    input  logic signed [15:0]      i_accel_y,
    input  logic signed [15:0]      i_accel_z,
    input  logic signed [15:0]      i_rate_x,
    input  logic signed [15:0]      i_rate_y,
    input  logic signed [15:0]      i_rate_z,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [15:0]      o_tilt_pitch,
    output logic signed [15:0]      o_tilt_roll,
    output logic signed [ACC_W-1:0] o_angle_x_sum,
    output logic signed [ACC_W-1:0] o_angle_y_sum,
    output logic signed [ACC_W-1:0] o_angle_z_sum,
    output logic                    o_sum_saturated
);

    t_cmd    cmd;
    t_status status;

    itgi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    itgi_dp #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_time_ms       (i_time_ms),
        .i_sample_ok     (i_sample_ok),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_rate_x        (i_rate_x),
        .i_rate_y        (i_rate_y),
        .i_rate_z        (i_rate_z),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_tilt_pitch    (o_tilt_pitch),
        .o_tilt_roll     (o_tilt_roll),
        .o_angle_x_sum   (o_angle_x_sum),
        .o_angle_y_sum   (o_angle_y_sum),
        .o_angle_z_sum   (o_angle_z_sum),
        .o_sum_saturated (o_sum_saturated)
    );

endmodule

>>> rtl/itgi_checker.sv
// ----------------------------------------------------------------------------
// itgi_checker
// Port-level checks on the integrator.
// ----------------------------------------------------------------------------
module itgi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_tilt_pitch,
    input logic [15:0] o_tilt_roll
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tilt_pitch))
        else $error("result dropped under stall");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_tilt_pitch) <= 16'sd23040 &&
                     $signed(o_tilt_pitch) >= -16'sd23040))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_tilt_roll) <= 16'sd23040 &&
                     $signed(o_tilt_roll) >= -16'sd23040))
        else $error("roll out of range");

endmodule

bind imu_tilt_and_gyro_integrator_top itgi_checker u_itgi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_tilt_pitch (o_tilt_pitch),
    .o_tilt_roll  (o_tilt_roll)
);
